FILE: sv/rbbs_pkg.sv
`default_nettype none

package rbbs_pkg;

	localparam int FW = 13;
	localparam int BW = 8;

	typedef enum logic [2:0] {
		MODE_PUSH  = 3'd0,
		MODE_POP   = 3'd1,
		MODE_PEEK  = 3'd2,
		MODE_FIND  = 3'd3,
		MODE_FILL  = 3'd4,
		MODE_CLEAR = 3'd5
	} mode_t;

	typedef struct packed {
		logic [2:0]    mode;
		logic [BW-1:0] data;
		logic [FW-1:0] position;
		logic [FW-1:0] length;
	} req_t;

	typedef struct packed {
		logic          ok;
		logic [BW-1:0] data_out;
		logic [FW-1:0] found_pos;
		logic [FW-1:0] used;
		logic [FW-1:0] free;
	} rsp_t;

endpackage

`default_nettype wire

FILE: sv/rbbs_mem.sv
`default_nettype none

module rbbs_mem #(
	parameter int DEPTH = 4096,
	parameter int AW = 12
) (
	input  wire logic                   clk,
	input  wire logic                   we,
	input  wire logic [AW-1:0]          waddr,
	input  wire logic [rbbs_pkg::BW-1:0] wdata,
	input  wire logic                   re,
	input  wire logic [AW-1:0]          raddr,
	output logic      [rbbs_pkg::BW-1:0] rdata
);

	logic [rbbs_pkg::BW-1:0] mem_q [DEPTH];
	logic [rbbs_pkg::BW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: sv/rbbs_mod.sv
`default_nettype none

module rbbs_mod #(
	parameter int DEPTH = 4096,
	parameter int AW = 12
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic [rbbs_pkg::FW-1:0] pos,
	output logic                         done,
	output logic      [AW-1:0]           rem
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int SH = rbbs_pkg::FW + AW;
	localparam int MW = rbbs_pkg::FW + 2;
	localparam int PRW = rbbs_pkg::FW + MW;
	localparam int QW = rbbs_pkg::FW + CW;
	localparam longint unsigned RECIP_L =
		((64'd1 << SH) + 64'(DEPTH) - 64'd1) / 64'(DEPTH);
	localparam logic [MW-1:0] RECIP = MW'(RECIP_L);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	logic                    v_s1;
	logic                    v_s2;
	logic [rbbs_pkg::FW-1:0] pos_s1;
	logic [rbbs_pkg::FW-1:0] pos_s2;
	logic [rbbs_pkg::FW-1:0] quo_s2;
	logic [PRW-1:0]          prod_x;
	logic [QW-1:0]           back_x;
	logic [rbbs_pkg::FW-1:0] rem_x;

	// The quotient comes from a multiply by the rounded-up reciprocal of DEPTH,
	// which is exact for every position of the field width.
	assign prod_x = PRW'(pos_s1) * PRW'(RECIP);
	assign back_x = QW'(quo_s2) * QW'(DEPTH_C);
	assign rem_x = pos_s2 - back_x[rbbs_pkg::FW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			pos_s1 <= pos;
		end
		if (v_s1) begin
			pos_s2 <= pos_s1;
			quo_s2 <= rbbs_pkg::FW'(prod_x >> SH);
		end
	end

	assign done = v_s2;
	assign rem = AW'(rem_x);

endmodule

`default_nettype wire

FILE: sv/ring_byte_buffer_with_search.sv
// Byte ring buffer of DEPTH entries with peek, search and fill.
// Requests arrive on req_valid/req_ready with a req_t beat; each request
// gives exactly one rsp_t beat on rsp_valid/rsp_ready, in request order.
// A request is taken only when the block is idle and its response register
// is empty or being emptied in the same cycle, so one request is in flight.
// Push, clear, refused operations and unused modes respond in the cycle after
// acceptance. Pop and peek read memory on acceptance and respond from ST_RD.
// Pushes can be taken on consecutive cycles while rsp_ready is high; a pop or
// peek passes through ST_RD first. Find reads one stored byte per cycle and
// responds on a match or after the last stored byte. Fill first reduces the
// start position modulo DEPTH in the two-stage reciprocal reduction, then
// writes one byte per cycle and responds once length bytes are written. The
// rates are set by the single read and single write port of the byte memory.
// While the receiver holds rsp_ready low the response is kept and no new
// request is taken. Reset empties the buffer and clears both pointers; the
// stored bytes themselves are not cleared and need no clearing pass.
`default_nettype none

module ring_byte_buffer_with_search #(
	parameter int DEPTH = 4096
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_ready,
	input  wire rbbs_pkg::req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_ready,
	output rbbs_pkg::rsp_t      rsp
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = CW + rbbs_pkg::FW;
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam logic [XW-1:0] DEPTH_X = XW'(DEPTH);
	localparam logic [AW-1:0] LAST_A = AW'(DEPTH - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_FIND,
		ST_MOD,
		ST_FILL
	} state_t;

	state_t                  state_q;
	rbbs_pkg::rsp_t          rsp_q;
	logic                    rsp_valid_q;
	logic [AW-1:0]           rd_q;
	logic [AW-1:0]           wr_q;
	logic [CW-1:0]           fill_q;
	logic [AW-1:0]           ptr_q;
	logic [CW-1:0]           iss_q;
	logic [rbbs_pkg::FW-1:0] fill_left_q;
	logic [rbbs_pkg::BW-1:0] data_q;
	logic                    v_s1;
	logic [CW-1:0]           idx_s1;

	logic                    acc;
	logic [XW-1:0]           fill_x;
	logic [XW-1:0]           free_x;
	logic [XW-1:0]           need_x;
	logic [XW-1:0]           pos_x;
	logic [XW-1:0]           peek_sum_x;
	logic [XW-1:0]           peek_addr_x;
	logic [XW-1:0]           fpos_x;
	logic [XW-1:0]           used_nx_x;
	logic [XW-1:0]           free_nx_x;
	logic                    push_ok;
	logic                    pop_ok;
	logic                    peek_ok;
	logic                    match;
	logic                    issue;
	logic                    rsp_load;
	logic [CW-1:0]           fill_nx;
	logic [AW-1:0]           rd_inc;
	logic [AW-1:0]           wr_inc;
	logic [AW-1:0]           ptr_inc;

	logic                    mem_we;
	logic [AW-1:0]           mem_waddr;
	logic [rbbs_pkg::BW-1:0] mem_wdata;
	logic                    mem_re;
	logic [AW-1:0]           mem_raddr;
	logic [rbbs_pkg::BW-1:0] mem_rdata;

	logic                    mod_start;
	logic                    mod_done;
	logic [AW-1:0]           mod_rem;

	function automatic rbbs_pkg::rsp_t mk_rsp(
		input logic                    ok,
		input logic [rbbs_pkg::BW-1:0] dout,
		input logic [rbbs_pkg::FW-1:0] fpos,
		input logic [rbbs_pkg::FW-1:0] used,
		input logic [rbbs_pkg::FW-1:0] freec
	);
		rbbs_pkg::rsp_t r;
		r.ok = ok;
		r.data_out = dout;
		r.found_pos = fpos;
		r.used = used;
		r.free = freec;
		return r;
	endfunction

	assign req_ready = (state_q == ST_IDLE) && (!rsp_valid_q || rsp_ready);
	assign acc = req_valid && req_ready;

	assign fill_x = XW'(fill_q);
	assign free_x = XW'(DEPTH_C - fill_q);
	assign need_x = (req.length == '0) ? XW'(1) : XW'(req.length);
	assign pos_x = XW'(req.position);
	assign push_ok = need_x <= free_x;
	assign pop_ok = need_x <= fill_x;
	assign peek_ok = pos_x < fill_x;
	assign peek_sum_x = XW'(rd_q) + pos_x;
	assign peek_addr_x = (peek_sum_x >= DEPTH_X) ? peek_sum_x - DEPTH_X : peek_sum_x;
	assign fpos_x = XW'(rd_q) + XW'(idx_s1);

	assign rd_inc = (rd_q == LAST_A) ? '0 : rd_q + AW'(1);
	assign wr_inc = (wr_q == LAST_A) ? '0 : wr_q + AW'(1);
	assign ptr_inc = (ptr_q == LAST_A) ? '0 : ptr_q + AW'(1);

	assign match = v_s1 && (mem_rdata == data_q);
	assign issue = (iss_q != fill_q) && !match;

	always_comb begin
		fill_nx = fill_q;
		if (acc) begin
			case (req.mode)
				rbbs_pkg::MODE_PUSH: begin
					if (push_ok) fill_nx = fill_q + CW'(1);
				end
				rbbs_pkg::MODE_POP: begin
					if (pop_ok) fill_nx = fill_q - CW'(1);
				end
				rbbs_pkg::MODE_CLEAR: begin
					fill_nx = '0;
				end
				default: begin
					fill_nx = fill_q;
				end
			endcase
		end
	end

	assign used_nx_x = XW'(fill_nx);
	assign free_nx_x = XW'(DEPTH_C - fill_nx);

	always_comb begin
		rsp_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					case (req.mode)
						rbbs_pkg::MODE_POP: begin
							rsp_load = !pop_ok;
						end
						rbbs_pkg::MODE_PEEK: begin
							rsp_load = !peek_ok;
						end
						rbbs_pkg::MODE_FIND, rbbs_pkg::MODE_FILL: begin
							rsp_load = 1'b0;
						end
						default: begin
							rsp_load = 1'b1;
						end
					endcase
				end
			end
			ST_RD: begin
				rsp_load = 1'b1;
			end
			ST_FIND: begin
				rsp_load = match || (!v_s1 && iss_q == fill_q);
			end
			ST_FILL: begin
				rsp_load = (fill_left_q == '0);
			end
			default: begin
				rsp_load = 1'b0;
			end
		endcase
	end

	always_comb begin
		mem_we = 1'b0;
		mem_waddr = wr_q;
		mem_wdata = req.data;
		mem_re = 1'b0;
		mem_raddr = rd_q;
		case (state_q)
			ST_IDLE: begin
				if (acc && req.mode == rbbs_pkg::MODE_PUSH && push_ok) begin
					mem_we = 1'b1;
				end
				if (acc && req.mode == rbbs_pkg::MODE_POP && pop_ok) begin
					mem_re = 1'b1;
				end
				if (acc && req.mode == rbbs_pkg::MODE_PEEK && peek_ok) begin
					mem_re = 1'b1;
					mem_raddr = peek_addr_x[AW-1:0];
				end
			end
			ST_FIND: begin
				mem_re = issue;
				mem_raddr = ptr_q;
			end
			ST_FILL: begin
				mem_we = (fill_left_q != '0);
				mem_waddr = ptr_q;
				mem_wdata = data_q;
			end
			default: begin
				mem_re = 1'b0;
			end
		endcase
	end

	assign mod_start = acc && (req.mode == rbbs_pkg::MODE_FILL);

	rbbs_mem #(
		.DEPTH(DEPTH),
		.AW(AW)
	) u_mem (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re(mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	rbbs_mod #(
		.DEPTH(DEPTH),
		.AW(AW)
	) u_mod (
		.clk(clk),
		.arst_n(arst_n),
		.start(mod_start),
		.pos(req.position),
		.done(mod_done),
		.rem(mod_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rsp_valid_q <= 1'b0;
			rd_q <= '0;
			wr_q <= '0;
			fill_q <= '0;
			v_s1 <= 1'b0;
		end else begin
			fill_q <= fill_nx;
			rsp_valid_q <= rsp_load || (rsp_valid_q && !rsp_ready);
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						data_q <= req.data;
						case (req.mode)
							rbbs_pkg::MODE_PUSH: begin
								if (push_ok) wr_q <= wr_inc;
								rsp_q <= mk_rsp(push_ok, '0, '0,
									used_nx_x[rbbs_pkg::FW-1:0],
									free_nx_x[rbbs_pkg::FW-1:0]);
							end
							rbbs_pkg::MODE_POP: begin
								if (pop_ok) begin
									rd_q <= rd_inc;
									state_q <= ST_RD;
								end else begin
									rsp_q <= mk_rsp(1'b0, '0, '0,
										used_nx_x[rbbs_pkg::FW-1:0],
										free_nx_x[rbbs_pkg::FW-1:0]);
								end
							end
							rbbs_pkg::MODE_PEEK: begin
								if (peek_ok) begin
									state_q <= ST_RD;
								end else begin
									rsp_q <= mk_rsp(1'b0, '0, '0,
										used_nx_x[rbbs_pkg::FW-1:0],
										free_nx_x[rbbs_pkg::FW-1:0]);
								end
							end
							rbbs_pkg::MODE_FIND: begin
								iss_q <= '0;
								ptr_q <= rd_q;
								v_s1 <= 1'b0;
								state_q <= ST_FIND;
							end
							rbbs_pkg::MODE_FILL: begin
								fill_left_q <= req.length;
								state_q <= ST_MOD;
							end
							rbbs_pkg::MODE_CLEAR: begin
								rd_q <= '0;
								wr_q <= '0;
								rsp_q <= mk_rsp(1'b1, '0, '0,
									used_nx_x[rbbs_pkg::FW-1:0],
									free_nx_x[rbbs_pkg::FW-1:0]);
							end
							default: begin
								rsp_q <= mk_rsp(1'b0, '0, '0,
									used_nx_x[rbbs_pkg::FW-1:0],
									free_nx_x[rbbs_pkg::FW-1:0]);
							end
						endcase
					end
				end
				ST_RD: begin
					rsp_q <= mk_rsp(1'b1, mem_rdata, '0,
						used_nx_x[rbbs_pkg::FW-1:0],
						free_nx_x[rbbs_pkg::FW-1:0]);
					state_q <= ST_IDLE;
				end
				ST_FIND: begin
					if (match) begin
						rsp_q <= mk_rsp(1'b1, '0, fpos_x[rbbs_pkg::FW-1:0],
							used_nx_x[rbbs_pkg::FW-1:0],
							free_nx_x[rbbs_pkg::FW-1:0]);
						v_s1 <= 1'b0;
						state_q <= ST_IDLE;
					end else if (!v_s1 && iss_q == fill_q) begin
						rsp_q <= mk_rsp(1'b0, '0, '0,
							used_nx_x[rbbs_pkg::FW-1:0],
							free_nx_x[rbbs_pkg::FW-1:0]);
						state_q <= ST_IDLE;
					end else begin
						v_s1 <= issue;
						idx_s1 <= iss_q;
						if (issue) begin
							iss_q <= iss_q + CW'(1);
							ptr_q <= ptr_inc;
						end
					end
				end
				ST_MOD: begin
					if (mod_done) begin
						ptr_q <= mod_rem;
						state_q <= ST_FILL;
					end
				end
				ST_FILL: begin
					if (fill_left_q == '0) begin
						rsp_q <= mk_rsp(1'b1, '0, '0,
							used_nx_x[rbbs_pkg::FW-1:0],
							free_nx_x[rbbs_pkg::FW-1:0]);
						state_q <= ST_IDLE;
					end else begin
						ptr_q <= ptr_inc;
						fill_left_q <= fill_left_q - rbbs_pkg::FW'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

`ifndef ASSERT_OFF
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= DEPTH_C)
		else $error("Fill count exceeds the buffer depth.");

	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q == '0 |-> rd_q == wr_q)
		else $error("Empty buffer with read and write pointers apart.");

	a_rsp_room: assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> (!rsp_valid_q || rsp_ready))
		else $error("Request taken while a response beat is stuck.");

	a_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("Memory read and write in the same cycle.");

	a_find_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIND |-> iss_q <= fill_q)
		else $error("Search ran past the stored bytes.");
`endif

endmodule

`default_nettype wire
